// File: hdl/s1s_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s1s_pkg
// Types, constants and helper functions shared by the seed derivation block.
// ----------------------------------------------------------------------------
package s1s_pkg;

  localparam int unsigned NumRounds  = 80;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned CfgHoldCyc = 4;

  localparam logic [63:0] LcgMul  = 64'h5d588b656c078965;
  localparam logic [63:0] LcgAdd  = 64'h0000000000269ec3;
  localparam logic [31:0] KeyBase = 32'hff2f0000;
  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] LenWord = 32'h000001a0;
  localparam logic [16:0] HalfDay = 17'd43200;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;
  localparam logic [31:0] IvE = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LANG  = 3'd0,
    REG_VER   = 3'd1,
    REG_CONS  = 3'd2,
    REG_MAC   = 3'd3,
    REG_YEAR  = 3'd4,
    REG_MONTH = 3'd5,
    REG_DAY   = 3'd6,
    REG_KEY   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0]  v_frame;
    logic [6:0]  gx_status;
    logic [15:0] timer_zero;
    logic [7:0]  vertical_count;
    logic [5:0]  second_of_minute;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
  } req_t;

  typedef struct packed {
    logic [31:0] seed_low;
    logic [31:0] seed_high;
  } res_t;

  // message words that follow from configuration only
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
    logic [31:0] w6;
    logic [31:0] w7;
    logic [31:0] w8;
    logic [31:0] w12;
    logic        pm_clear;
  } static_words_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha_state_t;

  typedef logic [15:0][31:0] msg_win_t;

  // rows of {base, alternate base, sequel word0, sequel word1}, index {lang, version}
  localparam logic [31:0] RomTab [28][4] = '{
    '{32'h022160b0, 32'h02760190, 32'h0, 32'h0},
    '{32'h022160d0, 32'h027601b0, 32'h0, 32'h0},
    '{32'h02200010, 32'h027a5f70, 32'h0209aee8, 32'h02039de9},
    '{32'h02200050, 32'h027a5e90, 32'h0209af28, 32'h02039e15},
    '{32'h02216070, 32'h027601f0, 32'h0, 32'h0},
    '{32'h02216070, 32'h027601f0, 32'h0, 32'h0},
    '{32'h021fffd0, 32'h027a6070, 32'h0209aea8, 32'h02039db9},
    '{32'h021ffff0, 32'h027a5fb0, 32'h0209aec8, 32'h02039de5},
    '{32'h02216030, 32'h02760230, 32'h0, 32'h0},
    '{32'h02216050, 32'h02760250, 32'h0, 32'h0},
    '{32'h02200030, 32'h027a5f90, 32'h0209af08, 32'h02039df9},
    '{32'h02200050, 32'h027a5ef0, 32'h0209af28, 32'h02039e25},
    '{32'h02215fb0, 32'h027601d0, 32'h0, 32'h0},
    '{32'h02215fd0, 32'h027601d0, 32'h0, 32'h0},
    '{32'h021fff10, 32'h027a5f70, 32'h0209ade8, 32'h02039d69},
    '{32'h021fff50, 32'h027a5ed0, 32'h0209ae28, 32'h02039d95},
    '{32'h02215ff0, 32'h027602f0, 32'h0, 32'h0},
    '{32'h02216010, 32'h027602f0, 32'h0, 32'h0},
    '{32'h021fff50, 32'h027a6110, 32'h0209ae28, 32'h02039d69},
    '{32'h021fff70, 32'h027a6010, 32'h0209ae48, 32'h02039d95},
    '{32'h02215f10, 32'h02761150, 32'h0, 32'h0},
    '{32'h02215f30, 32'h02761150, 32'h0, 32'h0},
    '{32'h021ff9b0, 32'h027aa730, 32'h0209a8dc, 32'h02039ac9},
    '{32'h021ff9d0, 32'h027aa5f0, 32'h0209a8fc, 32'h02039af5},
    '{32'h022167b0, 32'h02761150, 32'h0, 32'h0},
    '{32'h022167b0, 32'h02761150, 32'h0, 32'h0},
    '{32'h02200750, 32'h02200770, 32'h0209b60c, 32'h0203a4d5},
    '{32'h02200770, 32'h027a57b0, 32'h0209b62c, 32'h0203a501}
  };

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // tens in the high nibble, units in the low nibble; v below 128
  function automatic logic [7:0] to_bcd8(input logic [6:0] v);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = {11'd0, v} * 18'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage
`default_nettype wire

// File: hdl/s1s_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s1s_cfg
// Configuration registers and the message words derived from them.
// ----------------------------------------------------------------------------
module s1s_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [s1s_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [s1s_pkg::CfgDataW-1:0]  cfg_data_i,
  output      s1s_pkg::static_words_t        words_o,
  output      logic                          hold_o
);
  import s1s_pkg::*;

  logic [2:0]  lang_q;
  logic [1:0]  ver_q, cons_q;
  logic [47:0] mac_q;
  logic [11:0] year_q, key_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [2:0]  hold_q, hold_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lang_q  <= '0;
      ver_q   <= '0;
      cons_q  <= '0;
      mac_q   <= '0;
      year_q  <= 12'd2000;
      month_q <= 4'd1;
      day_q   <= 5'd1;
      key_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LANG:  lang_q  <= cfg_data_i[2:0];
        REG_VER:   ver_q   <= cfg_data_i[1:0];
        REG_CONS:  cons_q  <= cfg_data_i[1:0];
        REG_MAC:   mac_q   <= cfg_data_i[47:0];
        REG_YEAR:  year_q  <= cfg_data_i[11:0];
        REG_MONTH: month_q <= cfg_data_i[3:0];
        REG_DAY:   day_q   <= cfg_data_i[4:0];
        REG_KEY:   key_q   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  // derived words settle after a write, while hold_o is high
  always_comb begin
    hold_d = hold_q;
    if (cfg_valid_i) begin
      hold_d = 3'(CfgHoldCyc);
    end else if (hold_q != '0) begin
      hold_d = hold_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else begin
      hold_q <= hold_d;
    end
  end

  assign hold_o = hold_q != '0;

  // rom words
  logic [2:0]  lang_c;
  logic [4:0]  rom_idx;
  logic [31:0] base, w0_d, w1_d, w2_d, w3_d;
  logic [31:0] w0_q, w1_q, w2_q, w3_q, w12_q;

  always_comb begin
    lang_c  = (lang_q > 3'd6) ? 3'd6 : lang_q;
    rom_idx = {lang_c, ver_q};
    base    = (cons_q != 2'd0) ? RomTab[rom_idx][1] : RomTab[rom_idx][0];
    if (ver_q[1]) begin
      w0_d = bswap32(RomTab[rom_idx][2]);
      w1_d = bswap32(RomTab[rom_idx][3]);
      w2_d = bswap32(base);
      w3_d = bswap32(base + 32'h54);
    end else begin
      w0_d = bswap32(base);
      w1_d = bswap32(base + 32'hfc);
      w2_d = w1_d;
      w3_d = bswap32(base + 32'h148);
    end
  end

  // date stage a
  logic        early;
  logic [13:0] yy_d, yy_q;
  logic [3:0]  mm_d;
  logic [24:0] d5_prod;
  logic [26:0] q100_prod;
  logic [8:0]  d5_q;
  logic [6:0]  q100_q;
  logic [21:0] y365_q;

  always_comb begin
    early     = month_q < 4'd3;
    yy_d      = 14'(year_q) + 14'd4800 - 14'(early);
    mm_d      = month_q + (early ? 4'd12 : 4'd0) - 4'd3;
    d5_prod   = 25'(11'(mm_d) * 11'd153 + 11'd2) * 25'd13108;
    q100_prod = 27'(yy_d) * 27'd5243;
  end

  always_ff @(posedge clk_i) begin
    w0_q   <= w0_d;
    w1_q   <= w1_d;
    w2_q   <= w2_d;
    w3_q   <= w3_d;
    w12_q  <= KeyBase - {key_q[11:4], 4'd0, key_q[3:0], 16'd0};
    yy_q   <= yy_d;
    d5_q   <= d5_prod[24:16];
    q100_q <= q100_prod[25:19];
    y365_q <= 22'(yy_q) * 22'd365;
  end

  // date stage b: julian day plus one
  logic [23:0] jd_q;

  always_ff @(posedge clk_i) begin
    jd_q <= 24'(day_q) + 24'(d5_q) + 24'(y365_q) + 24'(yy_q[13:2]) - 24'(q100_q)
          + 24'(q100_q[6:2]) - 24'd32044;
  end

  // date stage c: weekday by octal digit sum, plus bcd fields
  logic [5:0]  s1;
  logic [3:0]  s2, s3;
  logic [2:0]  wday;
  logic [24:0] yq_prod;
  logic [6:0]  yr_mod;
  logic [31:0] w8_q;

  always_comb begin
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(jd_q[3*i +: 3]);
    end
    s2      = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3      = 4'(s2[3]) + 4'(s2[2:0]);
    wday    = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    yq_prod = 25'(year_q) * 25'd5243;
    yr_mod  = 7'(year_q - 12'(yq_prod[24:19]) * 12'd100);
  end

  always_ff @(posedge clk_i) begin
    w8_q <= {to_bcd8(yr_mod), to_bcd8(7'(month_q)), to_bcd8(7'(day_q)), 5'd0, wday};
  end

  always_comb begin
    words_o.w0       = w0_q;
    words_o.w1       = w1_q;
    words_o.w2       = w1_q;
    words_o.w3       = w2_q;
    words_o.w4       = w3_q;
    if (!ver_q[1]) begin
      words_o.w2 = w1_q;
      words_o.w3 = w3_q;
    end else begin
      words_o.w2 = w2_q;
      words_o.w3 = w3_q;
    end
    words_o.w4       = w3_q;
    words_o.w6       = {16'd0, mac_q[15:0]};
    words_o.w7       = mac_q[47:16];
    words_o.w8       = w8_q;
    words_o.w12      = w12_q;
    words_o.pm_clear = cons_q == 2'd2;
  end

endmodule
`default_nettype wire

// File: hdl/s1s_msg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s1s_msg
// Builds the registered 16-word message block for one request.
// ----------------------------------------------------------------------------
module s1s_msg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  input       s1s_pkg::req_t          req_i,
  input       s1s_pkg::static_words_t words_i,
  output      logic                   valid_o,
  output      s1s_pkg::msg_win_t      win_o
);
  import s1s_pkg::*;

  logic [16:0] secs;
  logic        pm;
  msg_win_t    win_d, win_q;
  logic        valid_q;

  always_comb begin
    secs = 17'(req_i.hour_of_day) * 17'd3600 + 17'(req_i.minute_of_hour) * 17'd60
         + 17'(req_i.second_of_minute);
    pm   = (req_i.hour_of_day >= 5'd12) ^ ((secs >= HalfDay) && words_i.pm_clear);
    win_d     = '0;
    win_d[0]  = words_i.w0;
    win_d[1]  = words_i.w1;
    win_d[2]  = words_i.w2;
    win_d[3]  = words_i.w3;
    win_d[4]  = words_i.w4;
    win_d[5]  = bswap32({8'd0, req_i.vertical_count, req_i.timer_zero});
    win_d[6]  = words_i.w6;
    win_d[7]  = words_i.w7 ^ {1'b0, req_i.v_frame, 24'd0} ^ {25'd0, req_i.gx_status};
    win_d[8]  = words_i.w8;
    win_d[9]  = {to_bcd8(7'(req_i.hour_of_day)), to_bcd8(7'(req_i.minute_of_hour)),
                 to_bcd8(7'(req_i.second_of_minute)), 8'd0} | {1'b0, pm, 30'd0};
    win_d[12] = words_i.w12;
    win_d[13] = PadWord;
    win_d[15] = LenWord;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign valid_o = valid_q;
  assign win_o   = win_q;

endmodule
`default_nettype wire

// File: hdl/s1s_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s1s_round
// One registered SHA-1 round with its message schedule step.
// ----------------------------------------------------------------------------
module s1s_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input       s1s_pkg::sha_state_t st_i,
  input       s1s_pkg::msg_win_t  win_i,
  output      logic               valid_o,
  output      s1s_pkg::sha_state_t st_o,
  output      s1s_pkg::msg_win_t  win_o
);
  import s1s_pkg::*;

  localparam int unsigned Phase = RoundIdx / 20;

  logic [31:0] f, k, t, wnew;
  sha_state_t  st_d, st_q;
  msg_win_t    win_d, win_q;
  logic        valid_q;

  always_comb begin
    case (Phase)
      0: begin
        f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
        k = K0;
      end
      1: begin
        f = st_i.b ^ st_i.c ^ st_i.d;
        k = K1;
      end
      2: begin
        f = (st_i.b & st_i.c) | (st_i.b & st_i.d) | (st_i.c & st_i.d);
        k = K2;
      end
      default: begin
        f = st_i.b ^ st_i.c ^ st_i.d;
        k = K3;
      end
    endcase
    t      = {st_i.a[26:0], st_i.a[31:27]} + f + st_i.e + k + win_i[0];
    st_d.a = t;
    st_d.b = st_i.a;
    st_d.c = {st_i.b[1:0], st_i.b[31:2]};
    st_d.d = st_i.c;
    st_d.e = st_i.d;
    wnew   = win_i[13] ^ win_i[8] ^ win_i[2] ^ win_i[0];
    win_d  = {{wnew[30:0], wnew[31]}, win_i[15:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    win_q <= win_d;
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign win_o   = win_q;

endmodule
`default_nettype wire

// File: hdl/s1s_lcg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// s1s_lcg
// Digest finish, byte swap and one 64-bit LCG step in three stages.
// ----------------------------------------------------------------------------
module s1s_lcg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input       s1s_pkg::sha_state_t st_i,
  output      logic                valid_o,
  output      s1s_pkg::res_t       res_o
);
  import s1s_pkg::*;

  logic [2:0]  valid_q;
  logic [31:0] xlo_q, xhi_q;
  logic [63:0] p0_q;
  logic [31:0] p1_q, p2_q;
  logic [63:0] p1_full, p2_full, acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // cross terms only matter in their low halves
  always_comb begin
    p1_full = 64'(xlo_q) * 64'(LcgMul[63:32]);
    p2_full = 64'(xhi_q) * 64'(LcgMul[31:0]);
  end

  always_ff @(posedge clk_i) begin
    xlo_q <= bswap32(st_i.a + IvA);
    xhi_q <= bswap32(st_i.b + IvB);
    p0_q  <= 64'(xlo_q) * 64'(LcgMul[31:0]);
    p1_q  <= p1_full[31:0];
    p2_q  <= p2_full[31:0];
    acc_q <= p0_q + {p1_q + p2_q, 32'd0} + LcgAdd;
  end

  assign valid_o         = valid_q[2];
  assign res_o.seed_low  = acc_q[31:0];
  assign res_o.seed_high = acc_q[63:32];

endmodule
`default_nettype wire

// File: hdl/sha1_seed_derivation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_seed_derivation
// Fully pipelined SHA-1 single-block seed derivation with one LCG step.
// ----------------------------------------------------------------------------
// One request is taken every clock while busy_o is low; each gives one result
// on res_o, strobed by res_valid_o for a single cycle, after the message
// register, one register stage per SHA-1 round (80), and three stages for
// the digest finish and the split 64-bit multiply. The receiver cannot stall
// the pipeline. After a configuration write busy_o stays high while the
// date, weekday and rom words settle.
module sha1_seed_derivation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output      logic                          busy_o,
  input       s1s_pkg::req_t                 req_i,
  output      logic                          res_valid_o,
  output      s1s_pkg::res_t                 res_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [s1s_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [s1s_pkg::CfgDataW-1:0]  cfg_data_i
);
  import s1s_pkg::*;

  static_words_t words;
  logic          hold;
  logic          accept;

  logic       stage_valid [NumRounds+1];
  sha_state_t stage_st    [NumRounds+1];
  msg_win_t   stage_win   [NumRounds+1];

  assign cfg_ready_o = 1'b1;
  assign busy_o      = hold;
  assign accept      = start_i && !hold;

  s1s_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .words_o     (words),
    .hold_o      (hold)
  );

  s1s_msg u_msg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .words_i (words),
    .valid_o (stage_valid[0]),
    .win_o   (stage_win[0])
  );

  assign stage_st[0] = '{a: IvA, b: IvB, c: IvC, d: IvD, e: IvE};

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    s1s_round #(
      .RoundIdx (r)
    ) u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[r]),
      .st_i    (stage_st[r]),
      .win_i   (stage_win[r]),
      .valid_o (stage_valid[r+1]),
      .st_o    (stage_st[r+1]),
      .win_o   (stage_win[r+1])
    );
  end

  s1s_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[NumRounds]),
    .st_i    (stage_st[NumRounds]),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives seed derivation requests through sha1_seed_derivation under several
// register settings and compares every strobed seed with a local SHA-1 plus
// LCG prediction, in request order.
// ----------------------------------------------------------------------------
module testbench;
  import s1s_pkg::*;

  class seed_board;
    logic [2:0]  lang;
    logic [1:0]  ver;
    logic [1:0]  cons;
    logic [47:0] mac;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [11:0] keys;
    res_t        seed_q[$];
    int          errors;

    function void reset_regs();
      lang = 0; ver = 0; cons = 0; mac = 0;
      year = 12'd2000; month = 4'd1; day = 5'd1; keys = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [47:0] data);
      case (idx)
        REG_LANG:  lang  = data[2:0];
        REG_VER:   ver   = data[1:0];
        REG_CONS:  cons  = data[1:0];
        REG_MAC:   mac   = data;
        REG_YEAR:  year  = data[11:0];
        REG_MONTH: month = data[3:0];
        REG_DAY:   day   = data[4:0];
        REG_KEY:   keys  = data[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rev(logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function logic [7:0] bcd(int unsigned v);
      return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function res_t derive_seed(req_t r);
      logic [31:0] w[80];
      logic [31:0] row[4];
      logic [31:0] base, a, b, c, d, e, f, k, t, kw;
      logic [63:0] acc;
      int unsigned early, yy, mm, jd, secs, l;
      res_t res;
      l = (lang > 6) ? 6 : lang;
      row = RomTab[l * 4 + ver];
      base = row[(cons != 0) ? 1 : 0];
      for (int i = 0; i < 80; i++) w[i] = 0;
      if (ver >= 2) begin
        w[0] = rev(row[2]);
        w[1] = rev(row[3]);
        w[2] = rev(base);
        w[3] = rev(base + 32'h54);
        w[4] = w[3];
      end else begin
        w[0] = rev(base);
        w[1] = rev(base + 32'hfc);
        w[2] = w[1];
        w[3] = rev(base + 32'h148);
        w[4] = w[3];
      end
      w[5] = rev({8'd0, r.vertical_count, r.timer_zero});
      w[6] = {16'd0, mac[15:0]};
      w[7] = mac[47:16] ^ ({25'd0, r.v_frame} << 24) ^ {25'd0, r.gx_status};
      // julian day number gives the weekday
      early = (month < 3) ? 1 : 0;
      yy = year + 4800 - early;
      mm = month + 12 * early - 3;
      jd = day + (153 * mm + 2) / 5 - 32045 + 365 * yy + yy / 4 - yy / 100 + yy / 400;
      w[8] = {bcd(year % 100), bcd(month), bcd(day), 8'((jd + 1) % 7)};
      w[9] = {bcd(r.hour_of_day), bcd(r.minute_of_hour), bcd(r.second_of_minute), 8'd0};
      if (r.hour_of_day >= 12) w[9] |= 32'h40000000;
      secs = r.hour_of_day * 3600 + r.minute_of_hour * 60 + r.second_of_minute;
      if (secs >= HalfDay && cons == 2) w[9] ^= 32'h40000000;
      kw = KeyBase;
      for (int i = 0; i < 12; i++)
        if (keys[i]) kw -= (i < 4) ? (32'h10000 << i) : (32'h1000000 << (i - 4));
      w[12] = kw;
      w[13] = PadWord;
      w[15] = LenWord;
      for (int i = 16; i < 80; i++)
        w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = IvA; b = IvB; c = IvC; d = IvD; e = IvE;
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d); k = K0;
        end else if (i < 40) begin
          f = b ^ c ^ d; k = K1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d); k = K2;
        end else begin
          f = b ^ c ^ d; k = K3;
        end
        t = rotl(a, 5) + f + e + k + w[i];
        e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      acc = {rev(b + IvB), rev(a + IvA)};
      acc = acc * LcgMul + LcgAdd;
      res.seed_low  = acc[31:0];
      res.seed_high = acc[63:32];
      return res;
    endfunction

    function void note_request(req_t r);
      seed_q = {seed_q, derive_seed(r)};
    endfunction

    function void check_seed(res_t got);
      res_t exp_s;
      if (seed_q.size() == 0) begin
        $display("%0t: unexpected seed %h", $time, got);
        errors++;
        return;
      end
      exp_s = seed_q.pop_front();
      if (got.seed_low !== exp_s.seed_low) begin
        $display("%0t: seed_low expected %h actual %h", $time, exp_s.seed_low, got.seed_low);
        errors++;
      end
      if (got.seed_high !== exp_s.seed_high) begin
        $display("%0t: seed_high expected %h actual %h", $time, exp_s.seed_high,
                 got.seed_high);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchLimit = 4000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  req_t                req = '0;
  logic                res_valid;
  res_t                res;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  quiet = 0;
  int                  idle_pct = 27;
  seed_board           board = new();

  always #4 clk = ~clk;

  sha1_seed_derivation i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_request(req);
      if (res_valid) board.check_seed(res);
      if ((start && !busy) || res_valid || (cfg_valid && cfg_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    @(posedge clk);
    while (board.seed_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [47:0] data);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(req_t r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
  endtask

  function automatic req_t make_request(bit wild);
    req_t r;
    if (wild) begin
      r = req_t'($bits(req_t)'({$urandom, $urandom}));
    end else begin
      r.v_frame          = 7'($urandom_range(99));
      r.gx_status        = 7'($urandom_range(99));
      r.timer_zero       = 16'($urandom);
      r.vertical_count   = 8'($urandom);
      r.second_of_minute = 6'($urandom_range(59));
      r.hour_of_day      = 5'($urandom_range(23));
      r.minute_of_hour   = 6'($urandom_range(59));
    end
    return r;
  endfunction

  function automatic req_t clock_req(int h, int m, int s);
    req_t r;
    r = make_request(1'b0);
    r.hour_of_day      = 5'(h);
    r.minute_of_hour   = 6'(m);
    r.second_of_minute = 6'(s);
    return r;
  endfunction

  task automatic random_settings(bit extreme);
    if (extreme) begin
      write_reg(REG_LANG, 48'd7);
      write_reg(REG_VER, 48'd3);
      write_reg(REG_CONS, 48'd3);
      write_reg(REG_MAC, {48{1'b1}});
      write_reg(REG_YEAR, 48'd4095);
      write_reg(REG_MONTH, 48'd15);
      write_reg(REG_DAY, 48'd31);
      write_reg(REG_KEY, 48'd4095);
    end else begin
      write_reg(REG_LANG, 48'($urandom_range(7)));
      write_reg(REG_VER, 48'($urandom_range(3)));
      write_reg(REG_CONS, 48'($urandom_range(3)));
      write_reg(REG_MAC, 48'({$urandom, $urandom}));
      write_reg(REG_YEAR, ($urandom_range(9) == 0) ? 48'($urandom_range(4095))
                                                  : 48'($urandom_range(2099, 2000)));
      write_reg(REG_MONTH, ($urandom_range(9) == 0) ? 48'($urandom_range(15))
                                                   : 48'($urandom_range(12, 1)));
      write_reg(REG_DAY, ($urandom_range(9) == 0) ? 48'($urandom_range(31))
                                                 : 48'($urandom_range(28, 1)));
      write_reg(REG_KEY, 48'($urandom_range(4095)));
    end
  endtask

  initial begin
    board.reset_regs();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and the pm boundary at reset settings
    send_request('0);
    send_request(req_t'({7'd99, 7'd99, 16'hffff, 8'hff, 6'd59, 5'd23, 6'd59}));
    send_request('1);
    send_request(clock_req(12, 0, 0));
    send_request(clock_req(11, 59, 59));
    send_request(clock_req(11, 63, 0));
    start <= 1'b0;
    drain();

    // pm flag cleared past noon for console two, and toggled by late minutes
    write_reg(REG_CONS, 48'd2);
    send_request(clock_req(12, 0, 0));
    send_request(clock_req(23, 59, 59));
    send_request(clock_req(11, 59, 59));
    send_request(clock_req(11, 63, 63));
    send_request(clock_req(0, 0, 0));
    send_request(clock_req(31, 63, 63));
    start <= 1'b0;
    drain();

    // language past six, alternate console three, out-of-range date
    write_reg(REG_LANG, 48'd7);
    write_reg(REG_CONS, 48'd3);
    write_reg(REG_MONTH, 48'd0);
    write_reg(REG_DAY, 48'd0);
    write_reg(REG_YEAR, 48'd0);
    send_request(clock_req(12, 30, 0));
    send_request(make_request(1'b1));
    start <= 1'b0;
    drain();
    write_reg(REG_VER, 48'd2);
    send_request(make_request(1'b0));
    start <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_settings(ph == 1);
      idle_pct = (ph == 3) ? 0 : 27;
      for (int n = 0; n < 200; n++) send_request(make_request($urandom_range(9) == 0));
      start <= 1'b0;
      drain();
    end

    repeat (120) @(posedge clk);
    if (board.errors == 0 && board.seed_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
